// File: hdl/odpc_pkg.sv
`default_nettype none
package odpc_pkg;

  localparam int LineDepth  = 1024;
  localparam int AddrBits   = $clog2(LineDepth);
  localparam int SampleBits = 16;
  localparam int ProdBits   = 2 * SampleBits + 1;
  localparam int ScaleShift = 56 - 2 * SampleBits;
  localparam int CordBits   = ProdBits + ScaleShift + 2;
  localparam int CordSteps  = 22;
  localparam int AngBits    = 26;
  localparam int PiCodeQ16  = 8355838;

  localparam logic [7:0] CodeZero   = 8'd127;
  localparam logic [7:0] CodeUp     = 8'd191;
  localparam logic [7:0] CodeDown   = 8'd63;
  localparam logic [1:0] RegThresh  = 2'd0;
  localparam logic [1:0] RegDStart  = 2'd1;
  localparam logic [1:0] RegDEnd    = 2'd2;

  typedef struct packed {
    logic [SampleBits-1:0] re;
    logic [SampleBits-1:0] im;
    logic [15:0]           wt;
  } line_entry_t;

  typedef struct packed {
    logic                  emit;
    logic                  direct;
    logic [7:0]            direct_code;
    logic                  xneg;
    logic                  ypos;
    logic                  yneg;
    logic [AddrBits-1:0]   depth;
  } tag_t;

  function automatic logic [AngBits-1:0] step_angle(input int i);
    logic [AngBits-1:0] a;
    case (i)
      0: a = 26'd2088959;  1: a = 26'd1233185;  2: a = 26'd651581;
      3: a = 26'd330753;   4: a = 26'd166018;   5: a = 26'd83090;
      6: a = 26'd41555;    7: a = 26'd20779;    8: a = 26'd10390;
      9: a = 26'd5195;     10: a = 26'd2597;    11: a = 26'd1299;
      12: a = 26'd649;     13: a = 26'd325;     14: a = 26'd162;
      15: a = 26'd81;      16: a = 26'd41;      17: a = 26'd20;
      18: a = 26'd10;      19: a = 26'd5;       20: a = 26'd3;
      21: a = 26'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Falling ramp shared by the four middle sections of the colour map.
  function automatic logic [7:0] jet_slope(input logic [5:0] k);
    logic [7:0] v;
    case (k)
      6'd0: v = 8'd252;  6'd1: v = 8'd247;  6'd2: v = 8'd242;  6'd3: v = 8'd236;
      6'd4: v = 8'd231;  6'd5: v = 8'd226;  6'd6: v = 8'd220;  6'd7: v = 8'd215;
      6'd8: v = 8'd210;  6'd9: v = 8'd205;  6'd10: v = 8'd199; 6'd11: v = 8'd194;
      6'd12: v = 8'd189; 6'd13: v = 8'd183; 6'd14: v = 8'd178; 6'd15: v = 8'd173;
      6'd16: v = 8'd167; 6'd17: v = 8'd162; 6'd18: v = 8'd157; 6'd19: v = 8'd151;
      6'd20: v = 8'd146; 6'd21: v = 8'd141; 6'd22: v = 8'd135; 6'd23: v = 8'd130;
      6'd24: v = 8'd125; 6'd25: v = 8'd120; 6'd26: v = 8'd114; 6'd27: v = 8'd109;
      6'd28: v = 8'd104; 6'd29: v = 8'd98;  6'd30: v = 8'd93;  6'd31: v = 8'd88;
      6'd32: v = 8'd82;  6'd33: v = 8'd77;  6'd34: v = 8'd72;  6'd35: v = 8'd66;
      6'd36: v = 8'd61;  6'd37: v = 8'd56;  6'd38: v = 8'd50;  6'd39: v = 8'd45;
      6'd40: v = 8'd40;  6'd41: v = 8'd35;  6'd42: v = 8'd29;  6'd43: v = 8'd24;
      6'd44: v = 8'd19;  6'd45: v = 8'd13;  6'd46: v = 8'd8;   6'd47: v = 8'd3;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] jet_rom(input logic [7:0] c);
    logic [7:0] r, g, b;
    logic [4:0] k;
    logic [7:0] fade;
    k    = (c < 8'd32) ? c[4:0] : ~c[4:0];
    fade = 8'd251 - {k, 3'b000} + {7'd0, k[4]};
    r = '0;
    g = '0;
    b = '0;
    case (c) inside
      [8'd0:8'd31]: begin
        r = fade; g = 8'd255; b = 8'd255;
      end
      [8'd32:8'd79]: begin
        g = jet_slope(6'(c - 8'd32)); b = 8'd255;
      end
      [8'd80:8'd127]: begin
        b = jet_slope(6'(c - 8'd80));
      end
      [8'd128:8'd175]: begin
        r = jet_slope(6'(8'd175 - c));
      end
      [8'd176:8'd223]: begin
        r = 8'd255; g = jet_slope(6'(8'd223 - c));
      end
      default: begin
        r = 8'd255; g = 8'd255; b = fade;
      end
    endcase
    return {b, g, r};
  endfunction

endpackage
`default_nettype wire

// File: hdl/oct_doppler_phase_colormap.sv
// Doppler phase colouring of OCT depth samples.
// Input channel: one complex depth sample per request with its weight, depth
// and a first-line flag. Output channel: one pixel per request (depth, phase
// code, jet colour) for samples inside the depth window of every line after
// the first. The previous line lives in a single-port synchronous memory that
// is read and rewritten at the same address in the cycle a sample is taken.
// Throughput is one sample per cycle while the receiver does not stall. The
// path from the input request to the pixel is the memory read, the product,
// 22 CORDIC stages and the colour lookup into the output register.
// The whole pipeline advances only when the output register is free or
// being taken, so a stalled receiver holds every stage and drops in_ready.
// Reset clears the valid bits and the registers to threshold 0 and window
// 0 to 1024; the line memory holds nothing valid until a line has passed.
// User must write registers via the plain write port while idle; unenforced.
`default_nettype none
module oct_doppler_phase_colormap
  import odpc_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [SampleBits-1:0] sample_real_i,
  input  wire logic signed [SampleBits-1:0] sample_imag_i,
  input  wire logic [15:0]                  sample_weight_i,
  input  wire logic [9:0]                   depth_index_i,
  input  wire logic                         first_line_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [9:0]                        pixel_depth_o,
  output logic [7:0]                        phase_code_o,
  output logic [23:0]                       pixel_color_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [15:0]                  cfg_data_i
);

  logic [15:0] thr_q;
  logic [10:0] dstart_q, dend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0; dstart_q <= '0; dend_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegThresh: thr_q    <= cfg_data_i;
        RegDStart: dstart_q <= cfg_data_i[10:0];
        RegDEnd:   dend_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  logic en, acc;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  line_entry_t rd;
  odpc_line_store u_store (
    .clk_i, .en_i(acc), .addr_i(depth_index_i[AddrBits-1:0]),
    .wdata_i('{re: sample_real_i, im: sample_imag_i, wt: sample_weight_i}),
    .rdata_o(rd)
  );

  logic v1_q, emit1_q;
  logic signed [SampleBits-1:0] r2_q, i2_q;
  logic [AddrBits-1:0] d1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= sample_real_i; i2_q <= sample_imag_i; d1_q <= depth_index_i;
      emit1_q <= !first_line_i && ({1'b0, depth_index_i} >= dstart_q)
                 && ({1'b0, depth_index_i} < dend_q);
    end
  end

  logic v2_q, emit2_q, mask2_q;
  logic [AddrBits-1:0] d2_q;
  logic signed [ProdBits-1:0] p1_q, p2_q, p3_q, p4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= ProdBits'($signed(rd.re) * r2_q);
      p2_q <= ProdBits'($signed(rd.im) * i2_q);
      p3_q <= ProdBits'($signed(rd.im) * r2_q);
      p4_q <= ProdBits'($signed(rd.re) * i2_q);
      mask2_q <= !(rd.wt > thr_q);
      emit2_q <= emit1_q; d2_q <= d1_q;
    end
  end

  logic signed [ProdBits-1:0] x, y;
  logic signed [CordBits-1:0] xc, yc;
  tag_t tg;
  always_comb begin
    x  = p1_q + p2_q;
    y  = p3_q - p4_q;
    xc = CordBits'(x) <<< ScaleShift;
    yc = CordBits'(y) <<< ScaleShift;
    if (x < 0) begin
      xc = -xc; yc = -yc;
    end
    tg.emit  = emit2_q;
    tg.depth = d2_q;
    tg.xneg  = x < 0;
    tg.ypos  = y > 0;
    tg.yneg  = y < 0;
    tg.direct = mask2_q || (x == 0);
    tg.direct_code = mask2_q ? CodeZero :
                     (y > 0) ? CodeUp : (y < 0) ? CodeDown : CodeZero;
  end

  logic cv;
  tag_t ct;
  logic [7:0] code;
  odpc_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .tag_i(tg),
    .x_i(xc), .y_i(yc), .valid_o(cv), .tag_o(ct), .code_o(code)
  );

  logic [23:0] jet [256];
  for (genvar k = 0; k < 256; k++) begin : g_jet
    assign jet[k] = jet_rom(8'(k));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= cv && ct.emit;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_depth_o <= ct.depth;
      phase_code_o  <= code;
      pixel_color_o <= jet[code];
    end
  end

endmodule
`default_nettype wire

// File: hdl/odpc_line_store.sv
`default_nettype none
module odpc_line_store
  import odpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [AddrBits-1:0] addr_i,
  input  wire line_entry_t         wdata_i,
  output line_entry_t              rdata_o
);

  line_entry_t mem_q [LineDepth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_o      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/odpc_cordic.sv
`default_nettype none
module odpc_cordic
  import odpc_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire tag_t                       tag_i,
  input  wire logic signed [CordBits-1:0] x_i,
  input  wire logic signed [CordBits-1:0] y_i,
  output logic                            valid_o,
  output tag_t                            tag_o,
  output logic [7:0]                      code_o
);

  logic signed [CordBits-1:0] x_q [1:CordSteps];
  logic signed [CordBits-1:0] y_q [1:CordSteps];
  logic signed [AngBits-1:0]  z_q [1:CordSteps];
  tag_t                       t_q [1:CordSteps];
  logic [CordSteps:1]         v_q;

  for (genvar s = 0; s < CordSteps; s++) begin : g_st
    logic signed [CordBits-1:0] xin, yin, xs, ys;
    logic signed [AngBits-1:0]  zin;
    tag_t                       tin;
    logic                       vin;
    if (s == 0) begin : g_head
      assign xin = x_i;
      assign yin = y_i;
      assign zin = '0;
      assign tin = tag_i;
      assign vin = valid_i;
    end else begin : g_body
      assign xin = x_q[s];
      assign yin = y_q[s];
      assign zin = z_q[s];
      assign tin = t_q[s];
      assign vin = v_q[s];
    end
    assign xs = xin >>> s;
    assign ys = yin >>> s;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[s+1] <= tin;
        if (yin > 0) begin
          x_q[s+1] <= xin + ys;
          y_q[s+1] <= yin - xs;
          z_q[s+1] <= zin + $signed(step_angle(s));
        end else if (yin < 0) begin
          x_q[s+1] <= xin - ys;
          y_q[s+1] <= yin + xs;
          z_q[s+1] <= zin - $signed(step_angle(s));
        end else begin
          x_q[s+1] <= xin;
          y_q[s+1] <= yin;
          z_q[s+1] <= zin;
        end
      end
    end
  end

  logic signed [AngBits-1:0] zs;
  logic signed [10:0]        c;
  always_comb begin
    zs = z_q[CordSteps] + AngBits'(PiCodeQ16);
    c  = 11'(zs >>> 16);
    if (t_q[CordSteps].xneg && t_q[CordSteps].ypos) c = c + 11'sd127;
    if (t_q[CordSteps].xneg && t_q[CordSteps].yneg) c = c - 11'sd127;
    if (c < 0) c = '0;
    if (c > 11'sd254) c = 11'sd254;
    code_o = t_q[CordSteps].direct ? t_q[CordSteps].direct_code : c[7:0];
  end
  assign valid_o = v_q[CordSteps];
  assign tag_o   = t_q[CordSteps];

endmodule
`default_nettype wire
